### rtl/cpu6502_pkg.sv
// cpu6502 execute unit shared types, operation codes and word layouts
`default_nettype none

package cpu6502_pkg;

	localparam int unsigned IN_TDATA_W  = 48;
	localparam int unsigned OUT_TDATA_W = 80;

	localparam logic [7:0] SP_RESET = 8'hFF;
	localparam logic [4:0] BCD_TEN  = 5'd10;

	typedef enum logic [5:0] {
		CMD_LDA = 6'd0,  CMD_LDX = 6'd1,  CMD_LDY = 6'd2,  CMD_STA = 6'd3,
		CMD_STX = 6'd4,  CMD_STY = 6'd5,  CMD_ADC = 6'd6,  CMD_SBC = 6'd7,
		CMD_AND = 6'd8,  CMD_ORA = 6'd9,  CMD_EOR = 6'd10, CMD_CMP = 6'd11,
		CMD_CPX = 6'd12, CMD_CPY = 6'd13, CMD_BIT = 6'd14, CMD_ASL = 6'd15,
		CMD_LSR = 6'd16, CMD_ROL = 6'd17, CMD_ROR = 6'd18, CMD_INC = 6'd19,
		CMD_DEC = 6'd20, CMD_INX = 6'd21, CMD_INY = 6'd22, CMD_DEX = 6'd23,
		CMD_DEY = 6'd24, CMD_TAX = 6'd25, CMD_TXA = 6'd26, CMD_TAY = 6'd27,
		CMD_TYA = 6'd28, CMD_TXS = 6'd29, CMD_TSX = 6'd30, CMD_CLC = 6'd31,
		CMD_SEC = 6'd32, CMD_CLD = 6'd33, CMD_SED = 6'd34, CMD_CLI = 6'd35,
		CMD_SEI = 6'd36, CMD_CLV = 6'd37, CMD_JMP = 6'd38, CMD_BPL = 6'd39,
		CMD_BMI = 6'd40, CMD_BVC = 6'd41, CMD_BVS = 6'd42, CMD_BCC = 6'd43,
		CMD_BCS = 6'd44, CMD_BNE = 6'd45, CMD_BEQ = 6'd46, CMD_NOP = 6'd47
	} cmd_t;

	typedef struct packed {
		logic n;
		logic v;
		logic d;
		logic i;
		logic z;
		logic c;
	} flags_t;

	function automatic logic [7:0] pack_status(flags_t f);
		return {f.n, f.v, 1'b1, 1'b0, f.d, f.i, f.z, f.c};
	endfunction

endpackage

`default_nettype wire

### rtl/cpu6502_execute_unit.sv
// 6502 execute unit: one decoded instruction per word, register file and flags
//
// Executes one decoded 6502 instruction per input word and returns one result word
// for each. A word is registered at the input, executed by a single pass of ALU,
// flag and branch logic against the architectural registers, and registered at the
// output, so a new word is taken every cycle while the output is not stalled; the state
// update of one instruction is written when it executes and is seen by the next one. The
// output register stalls only on m_tready low, and the input register keeps taking
// words while the output word waits as long as it is empty. After reset A, X, Y are
// zero, SP is 0xFF and all flags are clear. No memory write gives address and data 0.
`default_nettype none

module cpu6502_execute_unit (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// command[5:0], operand[13:6], address[29:14], pc[45:30], zero fill
	input  wire logic [cpu6502_pkg::IN_TDATA_W-1:0]     s_tdata,
	// acc_mode[0]
	input  wire logic                                   s_tuser,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// write_address[15:0], write_data[23:16], next_pc[39:24], acc_out[47:40],
	// x_out[55:48], y_out[63:56], sp_out[71:64], status_out[79:72]
	output logic [cpu6502_pkg::OUT_TDATA_W-1:0]         m_tdata,
	// write_enable[0]
	output logic                                        m_tuser
);
	import cpu6502_pkg::*;

	// input stage
	logic        vld_s1;
	cmd_t        cmd_s1;
	logic [7:0]  opnd_s1;
	logic [15:0] addr_s1;
	logic [15:0] pc_s1;
	logic        accm_s1;

	// output stage
	logic        vld_s2;
	logic        we_s2;
	logic [15:0] waddr_s2;
	logic [7:0]  wdata_s2;
	logic [15:0] npc_s2;
	logic [7:0]  a_s2, x_s2, y_s2, sp_s2, st_s2;

	// architectural state
	logic [7:0]  a_q, x_q, y_q, sp_q;
	flags_t      fl_q;

	logic out_free, exec;

	assign out_free = !vld_s2 || m_tready;
	assign exec     = vld_s1 && out_free;
	assign s_tready = !vld_s1 || out_free;

	// next state and result
	logic [7:0]  a_d, x_d, y_d, sp_d;
	flags_t      fl_d;
	logic        we_d;
	logic [7:0]  wd_d;
	logic [15:0] npc_d;
	logic        take;

	logic [7:0]  addend;
	logic [8:0]  bsum;
	logic [4:0]  alo, ahi, slo, shi;
	logic        adc_dc, sbc_nob;
	logic [7:0]  adc_bcd, sbc_bcd;
	logic [7:0]  cmp_reg;
	logic [8:0]  cmp_diff;
	logic [7:0]  sh_in, sh_out;
	logic        sh_c;
	logic [7:0]  nz_val;
	logic        nz_upd;

	always_comb begin
		// binary add, sbc adds the complement
		addend = (cmd_s1 == CMD_SBC) ? ~opnd_s1 : opnd_s1;
		bsum   = {1'b0, a_q} + {1'b0, addend} + {8'd0, fl_q.c};

		// decimal add, digits masked to four bits
		alo    = {1'b0, a_q[3:0]} + {1'b0, opnd_s1[3:0]} + {4'd0, fl_q.c};
		adc_dc = alo > 5'd9;
		if (adc_dc) begin
			alo = alo - BCD_TEN;
		end
		ahi = {1'b0, a_q[7:4]} + {1'b0, opnd_s1[7:4]} + {4'd0, adc_dc};
		adc_bcd = {(ahi > 5'd9) ? ahi[3:0] - BCD_TEN[3:0] : ahi[3:0], alo[3:0]};

		// decimal subtract, bit 4 is the digit borrow
		slo     = {1'b0, a_q[3:0]} - {1'b0, opnd_s1[3:0]} - {4'd0, !fl_q.c};
		sbc_nob = !slo[4];
		if (!sbc_nob) begin
			slo = slo + BCD_TEN;
		end
		shi = {1'b0, a_q[7:4]} - {1'b0, opnd_s1[7:4]} - 5'd1 + {4'd0, sbc_nob};
		sbc_bcd = {shi[4] ? shi[3:0] + BCD_TEN[3:0] : shi[3:0], slo[3:0]};

		// compare
		case (cmd_s1)
			CMD_CPX: cmp_reg = x_q;
			CMD_CPY: cmp_reg = y_q;
			default: cmp_reg = a_q;
		endcase
		cmp_diff = {1'b0, cmp_reg} - {1'b0, opnd_s1};

		// shifter
		sh_in = accm_s1 ? a_q : opnd_s1;
		case (cmd_s1)
			CMD_ASL: begin
				sh_out = {sh_in[6:0], 1'b0};
				sh_c   = sh_in[7];
			end
			CMD_LSR: begin
				sh_out = {1'b0, sh_in[7:1]};
				sh_c   = sh_in[0];
			end
			CMD_ROL: begin
				sh_out = {sh_in[6:0], fl_q.c};
				sh_c   = sh_in[7];
			end
			default: begin
				sh_out = {fl_q.c, sh_in[7:1]};
				sh_c   = sh_in[0];
			end
		endcase

		a_d    = a_q;
		x_d    = x_q;
		y_d    = y_q;
		sp_d   = sp_q;
		fl_d   = fl_q;
		we_d   = 1'b0;
		wd_d   = 8'd0;
		npc_d  = pc_s1;
		take   = 1'b0;
		nz_val = 8'd0;
		nz_upd = 1'b0;

		unique case (cmd_s1) inside
			CMD_LDA: begin a_d = opnd_s1; nz_val = opnd_s1; nz_upd = 1'b1; end
			CMD_LDX: begin x_d = opnd_s1; nz_val = opnd_s1; nz_upd = 1'b1; end
			CMD_LDY: begin y_d = opnd_s1; nz_val = opnd_s1; nz_upd = 1'b1; end
			CMD_STA: begin we_d = 1'b1; wd_d = a_q; end
			CMD_STX: begin we_d = 1'b1; wd_d = x_q; end
			CMD_STY: begin we_d = 1'b1; wd_d = y_q; end
			CMD_ADC, CMD_SBC: begin
				if (fl_q.d) begin
					if (cmd_s1 == CMD_ADC) begin
						a_d    = adc_bcd;
						fl_d.c = ahi > 5'd9;
					end else begin
						a_d    = sbc_bcd;
						fl_d.c = !shi[4];
					end
				end else begin
					a_d    = bsum[7:0];
					fl_d.c = bsum[8];
					fl_d.v = !(a_q[7] ^ addend[7]) && (a_q[7] ^ bsum[7]);
				end
				nz_val = a_d;
				nz_upd = 1'b1;
			end
			CMD_AND: begin a_d = a_q & opnd_s1; nz_val = a_d; nz_upd = 1'b1; end
			CMD_ORA: begin a_d = a_q | opnd_s1; nz_val = a_d; nz_upd = 1'b1; end
			CMD_EOR: begin a_d = a_q ^ opnd_s1; nz_val = a_d; nz_upd = 1'b1; end
			CMD_CMP, CMD_CPX, CMD_CPY: begin
				fl_d.z = cmp_reg == opnd_s1;
				fl_d.c = !cmp_diff[8];
				fl_d.n = cmp_diff[7];
			end
			CMD_BIT: begin
				fl_d.z = (a_q & opnd_s1) == 8'd0;
				fl_d.n = opnd_s1[7];
				fl_d.v = opnd_s1[6];
			end
			CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
				fl_d.c = sh_c;
				nz_val = sh_out;
				nz_upd = 1'b1;
				if (accm_s1) begin
					a_d = sh_out;
				end else begin
					we_d = 1'b1;
					wd_d = sh_out;
				end
			end
			CMD_INC: begin
				we_d = 1'b1; wd_d = opnd_s1 + 8'd1; nz_val = wd_d; nz_upd = 1'b1;
			end
			CMD_DEC: begin
				we_d = 1'b1; wd_d = opnd_s1 - 8'd1; nz_val = wd_d; nz_upd = 1'b1;
			end
			CMD_INX: begin x_d = x_q + 8'd1; nz_val = x_d; nz_upd = 1'b1; end
			CMD_INY: begin y_d = y_q + 8'd1; nz_val = y_d; nz_upd = 1'b1; end
			CMD_DEX: begin x_d = x_q - 8'd1; nz_val = x_d; nz_upd = 1'b1; end
			CMD_DEY: begin y_d = y_q - 8'd1; nz_val = y_d; nz_upd = 1'b1; end
			CMD_TAX: begin x_d = a_q; nz_val = a_q; nz_upd = 1'b1; end
			CMD_TXA: begin a_d = x_q; nz_val = x_q; nz_upd = 1'b1; end
			CMD_TAY: begin y_d = a_q; nz_val = a_q; nz_upd = 1'b1; end
			CMD_TYA: begin a_d = y_q; nz_val = y_q; nz_upd = 1'b1; end
			CMD_TXS: sp_d = x_q;
			CMD_TSX: begin x_d = sp_q; nz_val = sp_q; nz_upd = 1'b1; end
			CMD_CLC: fl_d.c = 1'b0;
			CMD_SEC: fl_d.c = 1'b1;
			CMD_CLD: fl_d.d = 1'b0;
			CMD_SED: fl_d.d = 1'b1;
			CMD_CLI: fl_d.i = 1'b0;
			CMD_SEI: fl_d.i = 1'b1;
			CMD_CLV: fl_d.v = 1'b0;
			CMD_JMP: npc_d = addr_s1;
			CMD_BPL: take = !fl_q.n;
			CMD_BMI: take = fl_q.n;
			CMD_BVC: take = !fl_q.v;
			CMD_BVS: take = fl_q.v;
			CMD_BCC: take = !fl_q.c;
			CMD_BCS: take = fl_q.c;
			CMD_BNE: take = !fl_q.z;
			CMD_BEQ: take = fl_q.z;
			default: begin
			end
		endcase

		if (nz_upd) begin
			fl_d.n = nz_val[7];
			fl_d.z = nz_val == 8'd0;
		end
		// taken branch, offset sign extended
		if (take) begin
			npc_d = pc_s1 + {{8{opnd_s1[7]}}, opnd_s1};
		end
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			a_q    <= 8'd0;
			x_q    <= 8'd0;
			y_q    <= 8'd0;
			sp_q   <= SP_RESET;
			fl_q   <= '0;
		end else begin
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (out_free) begin
				vld_s2 <= vld_s1;
			end
			if (exec) begin
				a_q  <= a_d;
				x_q  <= x_d;
				y_q  <= y_d;
				sp_q <= sp_d;
				fl_q <= fl_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= cmd_t'(s_tdata[5:0]);
			opnd_s1 <= s_tdata[13:6];
			addr_s1 <= s_tdata[29:14];
			pc_s1   <= s_tdata[45:30];
			accm_s1 <= s_tuser;
		end
		if (exec) begin
			we_s2    <= we_d;
			waddr_s2 <= we_d ? addr_s1 : 16'd0;
			wdata_s2 <= wd_d;
			npc_s2   <= npc_d;
			a_s2     <= a_d;
			x_s2     <= x_d;
			y_s2     <= y_d;
			sp_s2    <= sp_d;
			st_s2    <= pack_status(fl_d);
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tuser  = we_s2;
	assign m_tdata  = {st_s2, sp_s2, y_s2, x_s2, a_s2, npc_s2, wdata_s2, waddr_s2};

endmodule

`default_nettype wire

### tb/cpu6502_execute_unit_tb.sv
// testbench for the 6502 execute unit: predicted instruction results checked word by word
`timescale 1ns / 100ps

module cpu6502_execute_unit_tb;
	import cpu6502_pkg::*;

	localparam int unsigned STALL_LIMIT  = 1000;
	localparam int unsigned DRAIN_CYCLES = 10;

	typedef struct {
		logic [5:0]  cmd;
		logic [7:0]  operand;
		logic [15:0] address;
		logic [15:0] pc;
		logic        acc_mode;
		int unsigned phase;
		logic        drain;
	} insn_t;

	typedef struct {
		logic        we;
		logic [15:0] waddr;
		logic [7:0]  wdata;
		logic [15:0] npc;
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  sp;
		logic [7:0]  status;
	} exec_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tuser;

	insn_t        queued_insns[$];
	exec_result_t predicted_results[$];
	int unsigned  err_count = 0;
	int unsigned  idle_cycles = 0;
	int unsigned  stim_phase = 0;
	logic         timed_out;

	// predicted architectural state
	logic [7:0] reg_a = 8'h00;
	logic [7:0] reg_x = 8'h00;
	logic [7:0] reg_y = 8'h00;
	logic [7:0] reg_sp = 8'hFF;
	flags_t     flg = '0;

	cpu6502_execute_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void update_nz(input logic [7:0] v);
		flg.n = v[7];
		flg.z = (v == 8'h00);
	endfunction

	function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
		logic [7:0] diff;
		diff = r - m;
		flg.z = (r == m);
		flg.c = (r >= m);
		flg.n = diff[7];
	endfunction

	function automatic void add_binary(input logic [7:0] m);
		logic [8:0] sum;
		logic [7:0] res;
		sum = {1'b0, reg_a} + {1'b0, m} + {8'h00, flg.c};
		res = sum[7:0];
		flg.v = ~(reg_a[7] ^ m[7]) & (reg_a[7] ^ res[7]);
		flg.c = sum[8];
		reg_a = res;
	endfunction

	function automatic void add_decimal(input logic [7:0] m);
		logic [4:0] lo;
		logic [4:0] hi;
		logic       dc;
		lo = {1'b0, reg_a[3:0]} + {1'b0, m[3:0]} + {4'h0, flg.c};
		dc = 1'b0;
		if (lo > 5'd9) begin
			lo = lo - 5'd10;
			dc = 1'b1;
		end
		hi = {1'b0, reg_a[7:4]} + {1'b0, m[7:4]} + {4'h0, dc};
		if (hi > 5'd9) begin
			hi = hi - 5'd10;
			flg.c = 1'b1;
		end else begin
			flg.c = 1'b0;
		end
		reg_a = {hi[3:0], lo[3:0]};
	endfunction

	function automatic void sub_decimal(input logic [7:0] m);
		logic [7:0] lo;
		logic [7:0] hi;
		logic       nob;
		lo = {4'h0, reg_a[3:0]} - {4'h0, m[3:0]} - {7'h00, ~flg.c};
		nob = ~lo[7];
		if (!nob)
			lo = lo + 8'h0A;
		hi = {4'h0, reg_a[7:4]} - {4'h0, m[7:4]} - 8'h01 + {7'h00, nob};
		flg.c = ~hi[7];
		if (!flg.c)
			hi = hi + 8'h0A;
		reg_a = {hi[3:0], lo[3:0]};
	endfunction

	function automatic logic [7:0] shift_byte(input logic [5:0] cmd, input logic [7:0] v);
		logic       cin;
		logic [7:0] r;
		cin = flg.c;
		case (cmd)
			CMD_ASL: begin
				flg.c = v[7];
				r = {v[6:0], 1'b0};
			end
			CMD_LSR: begin
				flg.c = v[0];
				r = {1'b0, v[7:1]};
			end
			CMD_ROL: begin
				flg.c = v[7];
				r = {v[6:0], cin};
			end
			default: begin
				flg.c = v[0];
				r = {cin, v[7:1]};
			end
		endcase
		update_nz(r);
		return r;
	endfunction

	// advances the predicted state by one instruction and returns its result word
	function automatic exec_result_t execute_insn(input insn_t it);
		exec_result_t r;
		logic [7:0]   m;
		logic [7:0]   wd;
		logic         we;
		logic         br;
		logic         take;
		logic [15:0]  npc;
		m = it.operand;
		wd = 8'h00;
		we = 1'b0;
		br = 1'b0;
		take = 1'b0;
		npc = it.pc;
		case (it.cmd)
			CMD_LDA: begin reg_a = m; update_nz(m); end
			CMD_LDX: begin reg_x = m; update_nz(m); end
			CMD_LDY: begin reg_y = m; update_nz(m); end
			CMD_STA: begin we = 1'b1; wd = reg_a; end
			CMD_STX: begin we = 1'b1; wd = reg_x; end
			CMD_STY: begin we = 1'b1; wd = reg_y; end
			CMD_ADC: begin
				if (flg.d)
					add_decimal(m);
				else
					add_binary(m);
				update_nz(reg_a);
			end
			CMD_SBC: begin
				if (flg.d)
					sub_decimal(m);
				else
					add_binary(~m);
				update_nz(reg_a);
			end
			CMD_AND: begin reg_a = reg_a & m; update_nz(reg_a); end
			CMD_ORA: begin reg_a = reg_a | m; update_nz(reg_a); end
			CMD_EOR: begin reg_a = reg_a ^ m; update_nz(reg_a); end
			CMD_CMP: compare_reg(reg_a, m);
			CMD_CPX: compare_reg(reg_x, m);
			CMD_CPY: compare_reg(reg_y, m);
			CMD_BIT: begin
				flg.z = ((reg_a & m) == 8'h00);
				flg.n = m[7];
				flg.v = m[6];
			end
			CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
				if (it.acc_mode) begin
					reg_a = shift_byte(it.cmd, reg_a);
				end else begin
					wd = shift_byte(it.cmd, m);
					we = 1'b1;
				end
			end
			CMD_INC: begin wd = m + 8'h01; update_nz(wd); we = 1'b1; end
			CMD_DEC: begin wd = m - 8'h01; update_nz(wd); we = 1'b1; end
			CMD_INX: begin reg_x = reg_x + 8'h01; update_nz(reg_x); end
			CMD_INY: begin reg_y = reg_y + 8'h01; update_nz(reg_y); end
			CMD_DEX: begin reg_x = reg_x - 8'h01; update_nz(reg_x); end
			CMD_DEY: begin reg_y = reg_y - 8'h01; update_nz(reg_y); end
			CMD_TAX: begin reg_x = reg_a; update_nz(reg_x); end
			CMD_TXA: begin reg_a = reg_x; update_nz(reg_a); end
			CMD_TAY: begin reg_y = reg_a; update_nz(reg_y); end
			CMD_TYA: begin reg_a = reg_y; update_nz(reg_a); end
			CMD_TXS: reg_sp = reg_x;
			CMD_TSX: begin reg_x = reg_sp; update_nz(reg_x); end
			CMD_CLC: flg.c = 1'b0;
			CMD_SEC: flg.c = 1'b1;
			CMD_CLD: flg.d = 1'b0;
			CMD_SED: flg.d = 1'b1;
			CMD_CLI: flg.i = 1'b0;
			CMD_SEI: flg.i = 1'b1;
			CMD_CLV: flg.v = 1'b0;
			CMD_JMP: npc = it.address;
			CMD_BPL: begin br = 1'b1; take = ~flg.n; end
			CMD_BMI: begin br = 1'b1; take = flg.n; end
			CMD_BVC: begin br = 1'b1; take = ~flg.v; end
			CMD_BVS: begin br = 1'b1; take = flg.v; end
			CMD_BCC: begin br = 1'b1; take = ~flg.c; end
			CMD_BCS: begin br = 1'b1; take = flg.c; end
			CMD_BNE: begin br = 1'b1; take = ~flg.z; end
			CMD_BEQ: begin br = 1'b1; take = flg.z; end
			default: ;
		endcase
		// taken branch: sign-extended offset, wraps at 64k
		if (br && take)
			npc = it.pc + {{8{m[7]}}, m};
		r.we = we;
		r.waddr = we ? it.address : 16'h0000;
		r.wdata = we ? wd : 8'h00;
		r.npc = npc;
		r.a = reg_a;
		r.x = reg_x;
		r.y = reg_y;
		r.sp = reg_sp;
		r.status = {flg.n, flg.v, 1'b1, 1'b0, flg.d, flg.i, flg.z, flg.c};
		return r;
	endfunction

	task automatic add_insn(input logic [5:0] cmd, input logic [7:0] operand,
		input logic [15:0] address, input logic [15:0] pc, input logic acc_mode,
		input int unsigned phase, input logic drain);
		insn_t it;
		it.cmd = cmd;
		it.operand = operand;
		it.address = address;
		it.pc = pc;
		it.acc_mode = acc_mode;
		it.phase = phase;
		it.drain = drain;
		queued_insns.push_back(it);
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h7F;
			3: return 8'h80;
			4: return {4'($urandom_range(9)), 4'($urandom_range(9))};
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_word();
		case ($urandom_range(19))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(3));
			3: return 16'hFFFF - 16'($urandom_range(3));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [5:0] rand_cmd();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 6)
			return 6'($urandom_range(63, 48));
		else if (r < 16)
			return $urandom_range(1) ? CMD_ADC : CMD_SBC;
		else if (r < 20)
			return $urandom_range(1) ? CMD_SED : CMD_CLD;
		else
			return 6'($urandom_range(47));
	endfunction

	function automatic int unsigned send_idle_pct(input int unsigned phase);
		case (phase)
			0: return 18;
			1: return 69;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned recv_idle_pct(input int unsigned phase);
		case (phase)
			0: return 69;
			1: return 18;
			default: return 0;
		endcase
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s expected %h got %h", name, exp_v, act_v);
			err_count++;
		end
	endtask

	// driver: holds a word until taken, then pulls the next instruction
	always @(posedge clk or negedge arst_n) begin : drive
		insn_t  head;
		logic   present;
		logic   hold;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				head = queued_insns.pop_front();
				predicted_results.push_back(execute_insn(head));
			end
			if (s_tvalid && !s_tready) begin
				present = 1'b1;
			end else begin
				present = 1'b0;
				if (queued_insns.size() > 0) begin
					head = queued_insns[0];
					hold = head.drain && (predicted_results.size() != 0);
					if (!hold && ($urandom_range(99) >= send_idle_pct(head.phase)))
						present = 1'b1;
					if (present) begin
						s_tdata <= {2'b00, head.pc, head.address, head.operand, head.cmd};
						s_tuser <= head.acc_mode;
						stim_phase <= head.phase;
					end
				end
			end
			s_tvalid <= present;
		end
	end

	// monitor: compares each result word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watch
		exec_result_t exp_r;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (predicted_results.size() == 0) begin
					$error("result word with no prediction waiting");
					err_count++;
				end else begin
					exp_r = predicted_results.pop_front();
					check_field("write_enable", 16'(exp_r.we), 16'(m_tuser));
					check_field("write_address", exp_r.waddr, m_tdata[15:0]);
					check_field("write_data", 16'(exp_r.wdata), 16'(m_tdata[23:16]));
					check_field("next_pc", exp_r.npc, m_tdata[39:24]);
					check_field("acc_out", 16'(exp_r.a), 16'(m_tdata[47:40]));
					check_field("x_out", 16'(exp_r.x), 16'(m_tdata[55:48]));
					check_field("y_out", 16'(exp_r.y), 16'(m_tdata[63:56]));
					check_field("sp_out", 16'(exp_r.sp), 16'(m_tdata[71:64]));
					check_field("status_out", 16'(exp_r.status), 16'(m_tdata[79:72]));
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct(stim_phase));
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : stimulus
		int unsigned phase_len[3];
		phase_len[0] = 540;
		phase_len[1] = 540;
		phase_len[2] = 545;
		timed_out = 1'b0;

		// directed: reset state, field extremes, decimal mode, wrapping branches
		add_insn(CMD_NOP, 8'h00, 16'h0000, 16'h0000, 1'b0, 0, 1'b0);
		add_insn(CMD_LDA, 8'h80, 16'hFFFF, 16'hFFFF, 1'b1, 0, 1'b0);
		add_insn(CMD_LDA, 8'h00, 16'h0000, 16'h1234, 1'b0, 0, 1'b0);
		add_insn(CMD_LDX, 8'hFF, 16'h0001, 16'h8000, 1'b0, 0, 1'b0);
		add_insn(CMD_LDY, 8'h7F, 16'h7FFF, 16'h0002, 1'b0, 0, 1'b0);
		add_insn(CMD_STX, 8'h00, 16'hFFFF, 16'h0003, 1'b0, 0, 1'b0);
		add_insn(CMD_STY, 8'hFF, 16'h0000, 16'h0004, 1'b1, 0, 1'b0);
		add_insn(CMD_LDA, 8'h7F, 16'h0000, 16'h0005, 1'b0, 0, 1'b0);
		add_insn(CMD_ADC, 8'h01, 16'h0000, 16'h0006, 1'b0, 0, 1'b0);
		add_insn(CMD_BVS, 8'h80, 16'h0000, 16'h0001, 1'b0, 0, 1'b0);
		add_insn(CMD_STA, 8'h00, 16'hAAAA, 16'h0007, 1'b0, 0, 1'b0);
		add_insn(CMD_SBC, 8'h01, 16'h0000, 16'h0008, 1'b0, 0, 1'b0);
		add_insn(CMD_SED, 8'h00, 16'h0000, 16'h0009, 1'b0, 0, 1'b0);
		add_insn(CMD_ADC, 8'hFF, 16'h0000, 16'h000A, 1'b0, 0, 1'b0);
		add_insn(CMD_SBC, 8'hFF, 16'h0000, 16'h000B, 1'b0, 0, 1'b0);
		add_insn(CMD_ADC, 8'h99, 16'h0000, 16'h000C, 1'b0, 0, 1'b0);
		add_insn(CMD_CLD, 8'h00, 16'h0000, 16'h000D, 1'b0, 0, 1'b0);
		add_insn(CMD_ASL, 8'h80, 16'h5555, 16'h000E, 1'b0, 0, 1'b0);
		add_insn(CMD_ROR, 8'h00, 16'h0000, 16'h000F, 1'b1, 0, 1'b0);
		add_insn(CMD_INC, 8'hFF, 16'hFFFE, 16'h0010, 1'b0, 0, 1'b0);
		add_insn(CMD_DEC, 8'h00, 16'h0100, 16'h0011, 1'b0, 0, 1'b0);
		add_insn(CMD_TXS, 8'h00, 16'h0000, 16'h0012, 1'b0, 0, 1'b0);
		add_insn(CMD_TSX, 8'h00, 16'h0000, 16'h0013, 1'b0, 0, 1'b0);
		add_insn(CMD_BNE, 8'h7F, 16'h0000, 16'hFFFF, 1'b0, 0, 1'b0);
		add_insn(CMD_BIT, 8'hC0, 16'h0000, 16'h0014, 1'b0, 0, 1'b0);
		add_insn(CMD_JMP, 8'h00, 16'hFFFF, 16'h0015, 1'b0, 0, 1'b0);
		add_insn(6'd63, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 0, 1'b0);

		for (int unsigned p = 0; p < 3; p++) begin
			for (int unsigned k = 0; k < phase_len[p]; k++) begin
				// a phase opens only once every word of the last one is back
				add_insn(rand_cmd(), rand_byte(), rand_word(), rand_word(),
					1'($urandom_range(1)), p,
					(k == 0) || ($urandom_range(149) == 0));
			end
		end

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (!(queued_insns.size() == 0 && predicted_results.size() == 0 && !s_tvalid)
			&& !timed_out) begin
			@(posedge clk);
			if (idle_cycles >= STALL_LIMIT)
				timed_out = 1'b1;
		end
		if (!timed_out)
			repeat (DRAIN_CYCLES) @(posedge clk);

		if (timed_out || err_count != 0 || predicted_results.size() != 0) begin
			$display("cpu6502_execute_unit_tb NOT OK");
		end else begin
			$display("cpu6502_execute_unit_tb OK");
		end
		$finish;
	end

endmodule
